@@ hdl/msort_pkg.sv @@
`timescale 1ns / 1ps
// Shared constants, types and helpers of the merge sort engine.
package msort_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int SET_SIZE   = 64;
    localparam int ADDR_W     = $clog2(SET_SIZE);
    localparam int CNT_W      = ADDR_W + 1;     // holds 0 .. SET_SIZE
    localparam int IDX_W      = CNT_W + 1;      // run bounds and widths before clamping

    typedef logic [DATA_WIDTH-1:0] data_t;
    typedef logic [ADDR_W-1:0]     addr_t;
    typedef logic [CNT_W-1:0]      cnt_t;
    typedef logic [IDX_W-1:0]      idx_t;

    // Buffer access request from the sequencer to the two buffer memories.
    typedef struct packed {
        logic  we_a;
        logic  we_b;
        logic  rd_en;
        logic  src_b;       // 1: reads go to buffer B, 0: to buffer A
        addr_t waddr;
        addr_t raddr0;
        addr_t raddr1;
        data_t wdata;
    } mem_req_t;

    // Signed ascending order on raw words.
    function automatic logic key_le(input data_t x, input data_t y);
        return $signed(x) <= $signed(y);
    endfunction

endpackage

@@ hdl/msort_ram.sv @@
`timescale 1ns / 1ps
// Generic RAM: one write port, two read ports with registered read data.
module msort_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr0,
    input  logic [ADDR_W-1:0] raddr1,
    output logic [WIDTH-1:0]  rdata0,
    output logic [WIDTH-1:0]  rdata1
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata0 <= mem[raddr0];
            rdata1 <= mem[raddr1];
        end
    end

endmodule

@@ hdl/msort_ctrl.sv @@
`timescale 1ns / 1ps
// Sequencer: load, bottom-up merge passes and readout of the sorted set.
module msort_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  msort_pkg::data_t    s_tdata,
    input  logic                s_tlast,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic                m_tlast,
    output logic                m_tuser,
    output msort_pkg::mem_req_t mem_req,
    input  msort_pkg::data_t    rdata0,
    input  msort_pkg::data_t    rdata1
);
    import msort_pkg::*;

    typedef enum logic [5:0] {
        ST_LOAD  = 6'b000001,
        ST_SETUP = 6'b000010,
        ST_RD    = 6'b000100,
        ST_CMP   = 6'b001000,
        ST_ORD   = 6'b010000,
        ST_OUT   = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    cnt_t   count_reg, count_next;
    logic   dropped_reg, dropped_next;
    logic   src_b_reg, src_b_next;
    idx_t   width_reg, width_next;
    idx_t   lo_reg, lo_next;
    cnt_t   mid_reg, mid_next;
    cnt_t   hi_reg, hi_next;
    cnt_t   i_reg, i_next;
    cnt_t   j_reg, j_next;
    cnt_t   k_reg, k_next;

    idx_t   n_ext;
    idx_t   sum_mid;
    idx_t   sum_hi;
    idx_t   width2;
    cnt_t   k_inc;
    logic   full;
    logic   take_i;

    assign n_ext   = {1'b0, count_reg};
    assign sum_mid = lo_reg + width_reg;
    assign width2  = width_reg << 1;
    assign sum_hi  = lo_reg + width2;
    assign k_inc   = k_reg + cnt_t'(1);
    assign full    = (count_reg == cnt_t'(SET_SIZE));
    assign take_i  = (i_reg < mid_reg) && ((j_reg >= hi_reg) || key_le(rdata0, rdata1));

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        dropped_next = dropped_reg;
        src_b_next   = src_b_reg;
        width_next   = width_reg;
        lo_next      = lo_reg;
        mid_next     = mid_reg;
        hi_next      = hi_reg;
        i_next       = i_reg;
        j_next       = j_reg;
        k_next       = k_reg;
        s_tready     = 1'b0;
        m_tvalid     = 1'b0;
        m_tlast      = 1'b0;
        m_tuser      = 1'b0;
        mem_req      = '0;
        mem_req.src_b = src_b_reg;

        unique case (state_reg)
            ST_LOAD:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    if (!full)
                    begin
                        mem_req.we_a  = 1'b1;
                        mem_req.waddr = count_reg[ADDR_W-1:0];
                        mem_req.wdata = s_tdata;
                        count_next    = count_reg + cnt_t'(1);
                    end
                    else
                    begin
                        dropped_next = 1'b1;
                    end
                    if (s_tlast)
                    begin
                        width_next = idx_t'(1);
                        lo_next    = '0;
                        src_b_next = 1'b0;
                        k_next     = '0;
                        // a set of one word needs no merge pass
                        if (count_next > cnt_t'(1))
                        begin
                            state_next = ST_SETUP;
                        end
                        else
                        begin
                            state_next = ST_ORD;
                        end
                    end
                end
            end

            ST_SETUP:
            begin
                mid_next   = (sum_mid > n_ext) ? count_reg : sum_mid[CNT_W-1:0];
                hi_next    = (sum_hi > n_ext) ? count_reg : sum_hi[CNT_W-1:0];
                i_next     = lo_reg[CNT_W-1:0];
                j_next     = mid_next;
                k_next     = lo_reg[CNT_W-1:0];
                state_next = ST_RD;
            end

            ST_RD:
            begin
                mem_req.rd_en  = 1'b1;
                mem_req.raddr0 = i_reg[ADDR_W-1:0];
                mem_req.raddr1 = j_reg[ADDR_W-1:0];
                state_next     = ST_CMP;
            end

            ST_CMP:
            begin
                mem_req.we_a  = src_b_reg;
                mem_req.we_b  = !src_b_reg;
                mem_req.waddr = k_reg[ADDR_W-1:0];
                mem_req.wdata = take_i ? rdata0 : rdata1;
                k_next        = k_inc;
                if (take_i)
                begin
                    i_next = i_reg + cnt_t'(1);
                end
                else
                begin
                    j_next = j_reg + cnt_t'(1);
                end
                if (k_inc == hi_reg)
                begin
                    if (sum_hi >= n_ext)
                    begin
                        // pass done: swap buffers, double the run width
                        width_next = width2;
                        src_b_next = !src_b_reg;
                        lo_next    = '0;
                        if (width2 >= n_ext)
                        begin
                            k_next     = '0;
                            state_next = ST_ORD;
                        end
                        else
                        begin
                            state_next = ST_SETUP;
                        end
                    end
                    else
                    begin
                        lo_next    = sum_hi;
                        state_next = ST_SETUP;
                    end
                end
                else
                begin
                    state_next = ST_RD;
                end
            end

            ST_ORD:
            begin
                mem_req.rd_en  = 1'b1;
                mem_req.raddr0 = k_reg[ADDR_W-1:0];
                state_next     = ST_OUT;
            end

            ST_OUT:
            begin
                m_tvalid = 1'b1;
                m_tlast  = (k_inc == count_reg);
                m_tuser  = dropped_reg;
                if (m_tready)
                begin
                    if (m_tlast)
                    begin
                        count_next   = '0;
                        dropped_next = 1'b0;
                        state_next   = ST_LOAD;
                    end
                    else
                    begin
                        k_next     = k_inc;
                        state_next = ST_ORD;
                    end
                end
            end

            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_LOAD;
            count_reg   <= '0;
            dropped_reg <= 1'b0;
            src_b_reg   <= 1'b0;
            width_reg   <= '0;
            lo_reg      <= '0;
            mid_reg     <= '0;
            hi_reg      <= '0;
            i_reg       <= '0;
            j_reg       <= '0;
            k_reg       <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            dropped_reg <= dropped_next;
            src_b_reg   <= src_b_next;
            width_reg   <= width_next;
            lo_reg      <= lo_next;
            mid_reg     <= mid_next;
            hi_reg      <= hi_next;
            i_reg       <= i_next;
            j_reg       <= j_next;
            k_reg       <= k_next;
        end
    end

endmodule

@@ hdl/merge_sort_engine_unit.sv @@
`timescale 1ns / 1ps
// Top level of the merge sort engine: two set buffers and the sequencer.
//
// Usage:
//   Input stream (s_*): one signed 32-bit word per beat in s_tdata; s_tlast
//   marks the final word of a set and starts the sort. Up to 64 words are
//   held; words beyond that are dropped and the set is flagged.
//   Output stream (m_*): the held words in ascending signed order, m_tlast
//   on the final one, m_tuser set on every word of a set that lost words.
// Timing:
//   Loading takes one cycle per word. Sorting runs ceil(log2(n)) bottom-up merge
//   passes between buffer A and buffer B; each merged word takes a read step
//   (read both run heads), then a compare step (compare and write), plus a
//   setup step per run pair. Readout reads each word from the buffer, then
//   presents it until m_tready.
//   The registered read data of the buffer memories sets these steps.
//   s_tready is low from the final input word until the last sorted word
//   has been taken.
// Reset and stall:
//   rst_n clears the word count and the dropped flag; buffer contents are
//   not cleared, and a stale word read past a run's end is never used.
//   A stalled receiver holds m_tvalid and the current word until m_tready.
module merge_sort_engine_unit (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  msort_pkg::data_t       s_tdata,   // [31:0] value
    input  logic                   s_tlast,   // last_in
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output msort_pkg::data_t       m_tdata,   // [31:0] sorted_value
    output logic                   m_tlast,   // last_out
    output logic                   m_tuser    // [0] overflow
);
    import msort_pkg::*;

    mem_req_t mem_req;
    data_t    a_rdata0;
    data_t    a_rdata1;
    data_t    b_rdata0;
    data_t    b_rdata1;
    data_t    rdata0;
    data_t    rdata1;

    // Buffer A: load target and source of the first merge pass.
    msort_ram #(
        .WIDTH  (DATA_WIDTH),
        .DEPTH  (SET_SIZE),
        .ADDR_W (ADDR_W)
    ) u_buf_a (
        .clk    (clk),
        .we     (mem_req.we_a),
        .waddr  (mem_req.waddr),
        .wdata  (mem_req.wdata),
        .re     (mem_req.rd_en && !mem_req.src_b),
        .raddr0 (mem_req.raddr0),
        .raddr1 (mem_req.raddr1),
        .rdata0 (a_rdata0),
        .rdata1 (a_rdata1)
    );

    // Buffer B: ping-pong partner of buffer A.
    msort_ram #(
        .WIDTH  (DATA_WIDTH),
        .DEPTH  (SET_SIZE),
        .ADDR_W (ADDR_W)
    ) u_buf_b (
        .clk    (clk),
        .we     (mem_req.we_b),
        .waddr  (mem_req.waddr),
        .wdata  (mem_req.wdata),
        .re     (mem_req.rd_en && mem_req.src_b),
        .raddr0 (mem_req.raddr0),
        .raddr1 (mem_req.raddr1),
        .rdata0 (b_rdata0),
        .rdata1 (b_rdata1)
    );

    // Read data of the current source buffer; the registered read data
    // holds while no read is issued, so it also serves as output word.
    assign rdata0  = mem_req.src_b ? b_rdata0 : a_rdata0;
    assign rdata1  = mem_req.src_b ? b_rdata1 : a_rdata1;
    assign m_tdata = rdata0;

    msort_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser),
        .mem_req  (mem_req),
        .rdata0   (rdata0),
        .rdata1   (rdata1)
    );

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking bench for the merge sort engine: random sets in, sorted words checked.
module testbench;

    import msort_pkg::*;

    typedef struct packed {
        data_t value;
        logic  last;
        logic  overflow;
    } sorted_word_t;

    // Tracks the set being loaded and the sorted words still owed by the block.
    class sort_scoreboard;
        data_t        held[$];
        bit           dropped;
        sorted_word_t owed[$];
        int           errors;

        function void note_word(data_t v, bit last);
            data_t        run[$];
            data_t        key;
            sorted_word_t w;
            int           j;
            if (held.size() < SET_SIZE)
                held.push_back(v);
            else
                dropped = 1;
            if (!last)
                return;
            run = held;
            // insertion sort, ascending signed; ties are indistinguishable
            for (int i = 1; i < run.size(); i++) begin
                key = run[i];
                j = i - 1;
                while (j >= 0 && $signed(run[j]) > $signed(key)) begin
                    run[j + 1] = run[j];
                    j--;
                end
                run[j + 1] = key;
            end
            for (int k = 0; k < run.size(); k++) begin
                w.value    = run[k];
                w.last     = (k == run.size() - 1);
                w.overflow = dropped;
                owed.push_back(w);
            end
            held.delete();
            dropped = 0;
        endfunction

        function void check_word(data_t v, logic last, logic overflow);
            sorted_word_t w;
            if (owed.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected word: value=%h last=%b overflow=%b",
                             v, last, overflow);
                return;
            end
            w = owed.pop_front();
            if (v !== w.value || last !== w.last || overflow !== w.overflow) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: expected value=%h last=%b overflow=%b, got %h %b %b",
                             w.value, w.last, w.overflow, v, last, overflow);
            end
        endfunction
    endclass

    logic  clk;
    logic  rst_n;
    logic  s_tvalid;
    logic  s_tready;
    data_t s_tdata;
    logic  s_tlast;
    logic  m_tvalid;
    logic  m_tready;
    data_t m_tdata;
    logic  m_tlast;
    logic  m_tuser;

    sort_scoreboard sb;
    bit             quiet;
    int             words_sent;

    merge_sort_engine_unit u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    initial clk = 1'b0;
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Drive one word, with an occasional idle burst ahead of it.
    task automatic send_word(input data_t v, input bit last);
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        sb.note_word(v, last);
        words_sent++;
    endtask

    // Mix of full-range, duplicate-heavy and extreme values.
    function automatic data_t pick_value();
        case ($urandom_range(0, 7))
            0, 1:    return data_t'($urandom_range(0, 15)) - data_t'(8);
            2:       return data_t'(32'h8000_0000) + data_t'($urandom_range(0, 2));
            3:       return data_t'(32'h7fff_ffff) - data_t'($urandom_range(0, 2));
            default: return data_t'($urandom);
        endcase
    endfunction

    task automatic send_set(input int count);
        for (int i = 0; i < count; i++)
            send_word(pick_value(), i == count - 1);
    endtask

    task automatic wait_drained();
        while (sb.owed.size() != 0) @(posedge clk);
    endtask

    // Receiver: ready in random stretches, broken by stall bursts until the quiet tail.
    initial
    begin
        m_tready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (!quiet && $urandom_range(0, 2) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge clk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_word(m_tdata, m_tlast, m_tuser);
    end

    initial
    begin
        int set_len;
        int set_no;
        sb = new();
        quiet = 1'b0;
        words_sent = 0;
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tlast  <= 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // single-word sets at both extremes
        send_word(32'h8000_0000, 1'b1);
        send_word(32'h7fff_ffff, 1'b1);
        // two words, reversed
        send_word(32'h7fff_ffff, 1'b0);
        send_word(32'h8000_0000, 1'b1);
        // equal values
        send_word(32'd5, 1'b0);
        send_word(32'd5, 1'b0);
        send_word(32'hffff_fffb, 1'b0);
        send_word(32'd5, 1'b1);
        // sign boundary around zero and the extremes
        send_word(32'h0000_0000, 1'b0);
        send_word(32'hffff_ffff, 1'b0);
        send_word(32'h0000_0001, 1'b0);
        send_word(32'h8000_0000, 1'b0);
        send_word(32'h7fff_ffff, 1'b0);
        send_word(32'h8000_0001, 1'b1);

        // hold off until the block has emptied
        s_tvalid <= 1'b0;
        wait_drained();
        repeat (20) @(posedge clk);

        // random sets: first exactly full, then one that overflows with last on a dropped word
        set_no = 0;
        while (words_sent < 414)
        begin
            if (set_no == 0)
                set_len = SET_SIZE;
            else if (set_no == 1)
                set_len = SET_SIZE + 2;
            else
                case ($urandom_range(0, 19))
                    0, 1:    set_len = $urandom_range(13, SET_SIZE - 1);
                    2:       set_len = SET_SIZE;
                    3:       set_len = $urandom_range(SET_SIZE + 1, SET_SIZE + 8);
                    default: set_len = $urandom_range(1, 12);
                endcase
            if (words_sent > 350)
                quiet = 1'b1;
            send_set(set_len);
            set_no++;
        end

        s_tvalid <= 1'b0;
        wait_drained();
        repeat (100) @(posedge clk);
        sb.errors += sb.owed.size();
        if (sb.errors == 0)
            $display("merge_sort_engine_unit verification clean");
        else
            $display("merge_sort_engine_unit verification failed");
        $finish;
    end

    initial
    begin
        #4_000_000;
        $display("merge_sort_engine_unit verification failed");
        $finish;
    end

endmodule
